// ===== hdl/aobu_pkg.sv =====
// ----------------------------------------------------------------------------
// aobu_pkg
// Shared types and constants of the OBU stream normalizer.
// ----------------------------------------------------------------------------
package aobu_pkg;

   localparam int unsigned MaxTileGroups = 512;
   localparam int unsigned MaxObuCount   = 1024;
   localparam int unsigned MaxUnitBytes  = 4194304;
   localparam int unsigned QueueDepth    = 4;
   localparam int unsigned EmitMax       = 7;

   localparam logic [1:0] ERR_OK          = 2'd0;
   localparam logic [1:0] ERR_PROTOCOL    = 2'd1;
   localparam logic [1:0] ERR_UNSUPPORTED = 2'd2;
   localparam logic [1:0] ERR_TOO_BIG     = 2'd3;

   localparam logic [1:0] CSR_ANNEX_B_MODE  = 2'd0;
   localparam logic [1:0] CSR_EXP_STILL     = 2'd1;
   localparam logic [1:0] CSR_EXP_FRAME     = 2'd2;
   localparam logic [1:0] CSR_EXP_SHOW      = 2'd3;

   typedef struct packed {
      logic       annex_b_mode;
      logic       expected_still_picture;
      logic [1:0] expected_frame_type;
      logic       expected_show_frame;
   } cfg_type;

   // one queue word: the bytes one input caused plus the optional status report
   typedef struct packed {
      logic [EmitMax-1:0][7:0] bytes;
      logic [2:0]              count;
      logic                    eou;
      logic [1:0]              code;
      logic [10:0]             units;
      logic                    seq;
   } entry_type;

   typedef struct packed {
      logic      not_empty;
      entry_type head;
   } qhead_type;

endpackage

// ===== hdl/aobu_req_if.sv =====
// ----------------------------------------------------------------------------
// aobu_req_if
// Input byte channel.
// ----------------------------------------------------------------------------
interface aobu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_unit;
   modport source (output valid, output data_byte, output end_of_unit, input ready);
   modport sink   (input valid, input data_byte, input end_of_unit, output ready);
endinterface

// ===== hdl/aobu_rsp_if.sv =====
// ----------------------------------------------------------------------------
// aobu_rsp_if
// Result channel: stream bytes and end-of-unit status words.
// ----------------------------------------------------------------------------
interface aobu_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        is_status;
   logic        run_last;
   logic [1:0]  status_code;
   logic [10:0] units_counted;
   logic        has_sequence_header;
   modport source (output valid, output out_byte, output is_status, output run_last,
                   output status_code, output units_counted, output has_sequence_header,
                   input ready);
   modport sink   (input valid, input out_byte, input is_status, input run_last,
                   input status_code, input units_counted, input has_sequence_header,
                   output ready);
endinterface

// ===== hdl/aobu_front.sv =====
// ----------------------------------------------------------------------------
// aobu_front
// Byte parser: LEB128 sizes, OBU headers, order and prefix checks; builds a
// queue word for each input byte that emits bytes or ends the unit.
// ----------------------------------------------------------------------------
module aobu_front (
   input  logic                clock,
   input  logic                reset,
   input  aobu_pkg::cfg_type   cfg,
   input  logic                in_valid,
   input  logic [7:0]          in_byte,
   input  logic                in_eou,
   input  logic                accept,
   output logic                push,
   output aobu_pkg::entry_type push_entry
);

   typedef enum logic [2:0] {
      P_START, P_FU, P_OBU_LEN, P_HDR, P_EXT, P_SIZE, P_PAYLOAD, P_HALT
   } phase_type;

   localparam logic [5:0] F_SEQ      = 6'd1;
   localparam logic [5:0] F_RKNOWN   = 6'd2;
   localparam logic [5:0] F_REDUCED  = 6'd4;
   localparam logic [5:0] F_FHDR     = 6'd8;
   localparam logic [5:0] F_FRAME    = 6'd16;
   localparam logic [5:0] F_COMPLETE = 6'd32;

   phase_type   phase_ff, phase_in;
   logic [31:0] leb_ff, leb_in;
   logic [2:0]  lidx_ff, lidx_in;
   logic [22:0] ubs_ff, ubs_in;
   logic [31:0] tus_ff, tus_in;
   logic [31:0] ful_ff, ful_in;
   logic [31:0] obl_ff, obl_in;
   logic [7:0]  hb_ff, hb_in;
   logic [10:0] oc_ff, oc_in;
   logic [9:0]  tgc_ff, tgc_in;
   logic [5:0]  of_ff, of_in;
   logic        fpp_ff, fpp_in;
   logic [1:0]  err_ff, err_in;

   function automatic logic [1:0] first_err(input logic [1:0] cur, input logic [1:0] code);
      return (cur == aobu_pkg::ERR_OK) ? code : cur;
   endfunction

   // LEB128 accumulate for the current byte
   logic [31:0] leb_acc;
   logic        leb_done, leb_over;
   logic [2:0]  leb_nidx;
   always_comb begin
      logic [39:0] sh;
      logic [31:0] base;
      logic        sat;
      base = (lidx_ff == 3'd0) ? 32'd0 : leb_ff;
      sh   = {33'd0, in_byte[6:0]};
      sat  = 1'b0;
      case (lidx_ff)
         3'd0: sh = sh;
         3'd1: sh = sh << 7;
         3'd2: sh = sh << 14;
         3'd3: sh = sh << 21;
         3'd4: begin
            sh  = sh << 28;
            sat = (in_byte[6:4] != 3'd0);
         end
         default: sat = (in_byte[6:0] != 7'd0);
      endcase
      leb_acc  = sat ? 32'hFFFF_FFFF : (base | sh[31:0]);
      leb_done = !in_byte[7];
      leb_over = in_byte[7] && (lidx_ff >= 3'd7);
      leb_nidx = (leb_done || leb_over) ? 3'd0 : lidx_ff + 3'd1;
   end

   always_comb begin
      phase_type   ph, phn;
      logic [31:0] lv, tus, ful, obl, psz;
      logic [2:0]  li;
      logic [22:0] ubs;
      logic [7:0]  hb;
      logic [10:0] oc;
      logic [9:0]  tgc;
      logic [5:0]  of;
      logic        fpp, annex, st, do_after, do_hdr, ok, boundary;
      logic [1:0]  err;
      logic [3:0]  typ;
      logic [2:0]  ne, ngrp;
      logic [4:0][6:0] grp;
      logic [6:0][7:0] em;

      phn = phase_ff; lv = leb_ff; li = lidx_ff; ubs = ubs_ff; tus = tus_ff;
      ful = ful_ff; obl = obl_ff; hb = hb_ff; oc = oc_ff; tgc = tgc_ff;
      of = of_ff; fpp = fpp_ff; err = err_ff;
      ph = phase_ff;
      annex = cfg.annex_b_mode;
      st = 1'b0; do_after = 1'b0; do_hdr = 1'b0; ok = 1'b0; psz = 32'd0;
      ne = 3'd0; em = '0; boundary = 1'b0; typ = 4'd0; ngrp = 3'd0; grp = '0;

      if (ubs <= 23'(aobu_pkg::MaxUnitBytes)) ubs = ubs + 23'd1;
      if (ubs > 23'(aobu_pkg::MaxUnitBytes)) begin
         err = first_err(err, aobu_pkg::ERR_TOO_BIG);
         phn = P_HALT;
      end

      if (err == aobu_pkg::ERR_OK) begin
         ph = phn;
         if (annex) begin
            if (ph != P_START) begin
               if (tus == 32'd0) begin
                  err = aobu_pkg::ERR_PROTOCOL; phn = P_HALT; st = 1'b1;
               end else tus = tus - 32'd1;
            end
            if (!st && ph != P_START && ph != P_FU) begin
               if (ful == 32'd0) begin
                  err = aobu_pkg::ERR_PROTOCOL; phn = P_HALT; st = 1'b1;
               end else ful = ful - 32'd1;
            end
         end else if (ph == P_START || ph == P_FU || ph == P_OBU_LEN) begin
            ph = P_HDR;
         end
         // byte count inside the OBU for header, extension and size fields
         if (!st && annex && (ph == P_HDR || ph == P_EXT || ph == P_SIZE)) begin
            if (obl == 32'd0) begin
               err = aobu_pkg::ERR_PROTOCOL; phn = P_HALT; st = 1'b1;
            end else obl = obl - 32'd1;
         end
         if (!st) begin
            if (ph == P_START || ph == P_FU || ph == P_OBU_LEN || ph == P_SIZE) begin
               lv = leb_acc; li = leb_nidx;
            end
            case (ph)
               P_START: begin
                  if (leb_over) begin
                     err = aobu_pkg::ERR_PROTOCOL; phn = P_HALT;
                  end else if (leb_done) begin
                     tus = lv; phn = P_FU;
                  end
               end
               P_FU: begin
                  if (leb_over) begin
                     err = aobu_pkg::ERR_PROTOCOL; phn = P_HALT;
                  end else if (leb_done) begin
                     ful = lv;
                     if (ful != tus) begin
                        err = aobu_pkg::ERR_PROTOCOL; phn = P_HALT;
                     end else phn = P_OBU_LEN;
                  end
               end
               P_OBU_LEN: begin
                  if (leb_over) begin
                     err = aobu_pkg::ERR_PROTOCOL; phn = P_HALT;
                  end else if (leb_done) begin
                     if (lv == 32'd0 || lv > ful) begin
                        err = aobu_pkg::ERR_PROTOCOL; phn = P_HALT;
                     end else begin
                        obl = lv; phn = P_HDR;
                     end
                  end
               end
               P_HDR: begin
                  hb = in_byte;
                  if ((in_byte & 8'h81) != 8'd0) begin
                     err = aobu_pkg::ERR_PROTOCOL; phn = P_HALT;
                  end else if (!annex && !in_byte[1]) begin
                     err = aobu_pkg::ERR_UNSUPPORTED; phn = P_HALT;
                  end else if (in_byte[2]) begin
                     if (annex && obl == 32'd0) begin
                        err = aobu_pkg::ERR_PROTOCOL; phn = P_HALT;
                     end else phn = P_EXT;
                  end else do_after = 1'b1;
               end
               P_EXT: begin
                  if (in_byte != 8'd0) begin
                     err = aobu_pkg::ERR_UNSUPPORTED; phn = P_HALT;
                  end else do_after = 1'b1;
               end
               P_SIZE: begin
                  if (leb_over) begin
                     err = aobu_pkg::ERR_PROTOCOL; phn = P_HALT;
                  end else if (leb_done) begin
                     if (!annex) begin
                        do_hdr = 1'b1; psz = lv;
                     end else if (lv != obl) begin
                        err = aobu_pkg::ERR_PROTOCOL; phn = P_HALT;
                     end else begin
                        do_hdr = 1'b1; psz = obl;
                     end
                  end
               end
               P_PAYLOAD: begin
                  if (obl == 32'd0) begin
                     err = aobu_pkg::ERR_PROTOCOL; phn = P_HALT;
                  end else begin
                     if (fpp) begin
                        fpp = 1'b0;
                        if (hb[6:3] == 4'd1) begin
                           if (in_byte[7:5] != 3'd0) begin
                              err = aobu_pkg::ERR_UNSUPPORTED; phn = P_HALT;
                           end else if (in_byte[4] != cfg.expected_still_picture ||
                                        (in_byte[3] && !in_byte[4])) begin
                              err = aobu_pkg::ERR_PROTOCOL; phn = P_HALT;
                           end else begin
                              of = of | F_RKNOWN | (in_byte[3] ? F_REDUCED : 6'd0);
                           end
                        end else begin
                           if (in_byte[7]) begin
                              err = aobu_pkg::ERR_UNSUPPORTED; phn = P_HALT;
                           end else if (in_byte[6:5] != cfg.expected_frame_type ||
                                        in_byte[4] != cfg.expected_show_frame) begin
                              err = aobu_pkg::ERR_PROTOCOL; phn = P_HALT;
                           end
                        end
                     end
                     if (err == aobu_pkg::ERR_OK) begin
                        obl = obl - 32'd1;
                        if (annex) begin
                           em[0] = in_byte; ne = 3'd1;
                        end
                        if (obl == 32'd0) phn = annex ? P_OBU_LEN : P_HDR;
                     end
                  end
               end
               default: ;
            endcase

            if (do_after) begin
               if (hb[1]) begin
                  if (annex && obl == 32'd0) begin
                     err = aobu_pkg::ERR_PROTOCOL; phn = P_HALT;
                  end else phn = P_SIZE;
               end else begin
                  do_hdr = 1'b1; psz = obl;
               end
            end

            if (do_hdr) begin
               typ = hb[6:3];
               if (oc >= 11'(aobu_pkg::MaxObuCount)) begin
                  err = aobu_pkg::ERR_TOO_BIG; phn = P_HALT;
               end else begin
                  oc = oc + 11'd1;
                  fpp = 1'b0;
                  ok = 1'b1;
                  case (typ)
                     4'd1: begin
                        if ((of & (F_SEQ | F_FHDR | F_FRAME)) != 6'd0) begin
                           err = aobu_pkg::ERR_UNSUPPORTED; ok = 1'b0;
                        end else begin
                           of = of | F_SEQ; fpp = 1'b1;
                        end
                     end
                     4'd2: begin
                        if (psz != 32'd0 || (of & (F_FHDR | F_FRAME)) != 6'd0 ||
                            tgc != 10'd0) begin
                           err = aobu_pkg::ERR_PROTOCOL; ok = 1'b0;
                        end
                     end
                     4'd3, 4'd6: begin
                        if ((of & (F_FHDR | F_FRAME)) != 6'd0 || tgc != 10'd0) begin
                           err = aobu_pkg::ERR_PROTOCOL; ok = 1'b0;
                        end else if ((of & F_RKNOWN) == 6'd0 &&
                                     cfg.expected_still_picture) begin
                           err = aobu_pkg::ERR_UNSUPPORTED; ok = 1'b0;
                        end else begin
                           of = of | F_RKNOWN;
                           if ((of & F_REDUCED) != 6'd0) begin
                              // reduced still header: the frame prefix is implied
                              if (cfg.expected_frame_type != 2'd0 ||
                                  !cfg.expected_show_frame) begin
                                 err = aobu_pkg::ERR_PROTOCOL; ok = 1'b0;
                              end
                           end else fpp = 1'b1;
                           if (ok) of = of | ((typ == 4'd3) ? F_FHDR : (F_FRAME | F_COMPLETE));
                        end
                     end
                     4'd4: begin
                        if ((of & F_FHDR) == 6'd0 || (of & F_FRAME) != 6'd0 ||
                            tgc >= 10'(aobu_pkg::MaxTileGroups)) begin
                           err = aobu_pkg::ERR_UNSUPPORTED; ok = 1'b0;
                        end else begin
                           tgc = tgc + 10'd1; of = of | F_COMPLETE;
                        end
                     end
                     4'd5: begin
                        if ((of & (F_FHDR | F_FRAME)) != 6'd0 || tgc != 10'd0) begin
                           err = aobu_pkg::ERR_UNSUPPORTED; ok = 1'b0;
                        end
                     end
                     4'd15: ;
                     default: begin
                        err = aobu_pkg::ERR_UNSUPPORTED; ok = 1'b0;
                     end
                  endcase
                  if (!ok) phn = P_HALT;
                  else if (fpp && psz == 32'd0) begin
                     err = aobu_pkg::ERR_PROTOCOL; phn = P_HALT;
                  end else begin
                     obl = psz;
                     phn = (psz != 32'd0) ? P_PAYLOAD : (annex ? P_OBU_LEN : P_HDR);
                  end
               end
               if (err == aobu_pkg::ERR_OK && annex) begin
                  // header with has_size, optional zero extension, minimal LEB128 size
                  em[0] = hb | 8'h02;
                  ne = 3'd1;
                  if (hb[2]) begin
                     em[1] = 8'd0; ne = 3'd2;
                  end
                  grp[0] = psz[6:0];   grp[1] = psz[13:7];  grp[2] = psz[20:14];
                  grp[3] = psz[27:21]; grp[4] = {3'd0, psz[31:28]};
                  if (grp[4] != 7'd0)      ngrp = 3'd5;
                  else if (grp[3] != 7'd0) ngrp = 3'd4;
                  else if (grp[2] != 7'd0) ngrp = 3'd3;
                  else if (grp[1] != 7'd0) ngrp = 3'd2;
                  else                     ngrp = 3'd1;
                  for (int g = 0; g < 5; g++) begin
                     if (3'(g) < ngrp) begin
                        em[3'(ne + 3'(g))] = {(3'(g) < ngrp - 3'd1), grp[g]};
                     end
                  end
                  ne = ne + ngrp;
               end
            end
         end
      end

      if (in_eou && err == aobu_pkg::ERR_OK) begin
         boundary = annex ? (phn == P_OBU_LEN && li == 3'd0 && ful == 32'd0 &&
                             tus == 32'd0)
                          : (phn == P_HDR);
         if (!boundary) err = aobu_pkg::ERR_PROTOCOL;
         else if (tgc == 10'd0 && (of & F_FRAME) == 6'd0) err = aobu_pkg::ERR_UNSUPPORTED;
      end
      if (!annex) begin
         em = '0; em[0] = in_byte; ne = 3'd1;
      end else if (err != aobu_pkg::ERR_OK) begin
         ne = 3'd0;
      end

      push_entry.bytes = em;
      push_entry.count = ne;
      push_entry.eou   = in_eou;
      push_entry.code  = err;
      push_entry.units = oc;
      push_entry.seq   = (of & F_SEQ) != 6'd0;
      push = accept && in_valid && (ne != 3'd0 || in_eou);

      if (in_eou) begin
         phn = P_START; lv = '0; li = '0; ubs = '0; tus = '0; ful = '0; obl = '0;
         hb = '0; oc = '0; tgc = '0; of = '0; fpp = 1'b0; err = aobu_pkg::ERR_OK;
      end
      phase_in = phn; leb_in = lv; lidx_in = li; ubs_in = ubs; tus_in = tus;
      ful_in = ful; obl_in = obl; hb_in = hb; oc_in = oc; tgc_in = tgc; of_in = of;
      fpp_in = fpp; err_in = err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_START; leb_ff <= '0; lidx_ff <= '0; ubs_ff <= '0; tus_ff <= '0;
         ful_ff <= '0; obl_ff <= '0; hb_ff <= '0; oc_ff <= '0; tgc_ff <= '0; of_ff <= '0;
         fpp_ff <= 1'b0; err_ff <= aobu_pkg::ERR_OK;
      end else if (accept && in_valid) begin
         phase_ff <= phase_in; leb_ff <= leb_in; lidx_ff <= lidx_in; ubs_ff <= ubs_in;
         tus_ff <= tus_in; ful_ff <= ful_in; obl_ff <= obl_in; hb_ff <= hb_in;
         oc_ff <= oc_in; tgc_ff <= tgc_in; of_ff <= of_in; fpp_ff <= fpp_in;
         err_ff <= err_in;
      end
   end

endmodule

// ===== hdl/aobu_queue.sv =====
// ----------------------------------------------------------------------------
// aobu_queue
// Short word queue between the parser and the result serializer.
// ----------------------------------------------------------------------------
module aobu_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  aobu_pkg::entry_type push_entry,
   input  logic                pop,
   output logic                full,
   output aobu_pkg::qhead_type head
);

   localparam int unsigned PtrW = $clog2(aobu_pkg::QueueDepth);

   aobu_pkg::entry_type         mem_ff [aobu_pkg::QueueDepth];
   logic [PtrW-1:0]             wr_ff, wr_in;
   logic [PtrW-1:0]             rd_ff, rd_in;
   logic [PtrW:0]               cnt_ff, cnt_in;
   logic                        do_push, do_pop;

   assign full    = (cnt_ff == (PtrW + 1)'(aobu_pkg::QueueDepth));
   assign do_push = push && !full;
   assign do_pop  = pop && (cnt_ff != '0);
   assign wr_in   = do_push ? wr_ff + 1'b1 : wr_ff;
   assign rd_in   = do_pop ? rd_ff + 1'b1 : rd_ff;
   assign cnt_in  = cnt_ff + (PtrW + 1)'(do_push) - (PtrW + 1)'(do_pop);

   assign head.not_empty = (cnt_ff != '0);
   assign head.head      = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== hdl/aobu_back.sv =====
// ----------------------------------------------------------------------------
// aobu_back
// Result serializer: turns each queue word into bytes plus, at end of unit, a
// status word, one per cycle unless rsp stalls, into the output register.
// ----------------------------------------------------------------------------
module aobu_back (
   input  logic                clock,
   input  logic                reset,
   input  aobu_pkg::qhead_type head,
   output logic                pop,
   aobu_rsp_if.source          rsp
);

   logic [2:0]  k_ff, k_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        stat_ff, stat_in;
   logic        last_ff, last_in;
   logic [1:0]  code_ff, code_in;
   logic [10:0] units_ff, units_in;
   logic        seq_ff, seq_in;
   logic [2:0]  total;
   logic        load, is_stat;

   assign total   = head.head.count + 3'(head.head.eou);
   assign load    = head.not_empty && (!valid_ff || rsp.ready);
   assign is_stat = (k_ff >= head.head.count);
   assign pop     = load && (k_ff == total - 3'd1);

   always_comb begin
      k_in     = k_ff;
      valid_in = valid_ff && !rsp.ready;
      byte_in  = byte_ff;
      stat_in  = stat_ff;
      last_in  = last_ff;
      code_in  = code_ff;
      units_in = units_ff;
      seq_in   = seq_ff;
      if (load) begin
         valid_in = 1'b1;
         k_in     = pop ? 3'd0 : k_ff + 3'd1;
         last_in  = pop;
         stat_in  = is_stat;
         byte_in  = is_stat ? 8'd0 : head.head.bytes[k_ff];
         code_in  = is_stat ? head.head.code : aobu_pkg::ERR_OK;
         units_in = is_stat ? head.head.units : 11'd0;
         seq_in   = is_stat && head.head.seq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0; valid_ff <= 1'b0;
      end else begin
         k_ff <= k_in; valid_ff <= valid_in;
      end
      byte_ff <= byte_in; stat_ff <= stat_in; last_ff <= last_in;
      code_ff <= code_in; units_ff <= units_in; seq_ff <= seq_in;
   end

   assign rsp.valid               = valid_ff;
   assign rsp.out_byte            = byte_ff;
   assign rsp.is_status           = stat_ff;
   assign rsp.run_last            = last_ff;
   assign rsp.status_code         = code_ff;
   assign rsp.units_counted       = units_ff;
   assign rsp.has_sequence_header = seq_ff;

endmodule

// ===== hdl/av1_obu_stream_normalizer_core.sv =====
// ----------------------------------------------------------------------------
// av1_obu_stream_normalizer_core
// AV1 access unit normalizer: raw OBU pass-through or Annex B to
// low-overhead OBU conversion with header, order and size checks.
// ----------------------------------------------------------------------------
// Takes one byte per cycle. The parser handles each byte in the cycle it is
// taken and writes at most one word to a four-deep queue; the serializer
// drains it at one result per cycle unless the output stalls. Ordinary bytes
// thus flow at one per cycle; an Annex B OBU header word expands to up to
// seven results (header, extension and size bytes), and the input stalls only
// once the queue fills behind such bursts. The end-of-unit byte adds a status
// word with the first latched error code, OBU count and sequence header flag,
// and clears the parse state for the next unit. The user writes configuration
// through the csr_ port only while idle, unenforced by the block; no read-back.
module av1_obu_stream_normalizer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [1:0]  csr_wr_data,
   aobu_req_if.sink    req_chan,
   aobu_rsp_if.source  rsp_chan
);

   aobu_pkg::cfg_type   cfg_ff, cfg_in;
   aobu_pkg::entry_type push_entry;
   aobu_pkg::qhead_type head;
   logic                push, pop, full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            aobu_pkg::CSR_ANNEX_B_MODE: cfg_in.annex_b_mode           = csr_wr_data[0];
            aobu_pkg::CSR_EXP_STILL:    cfg_in.expected_still_picture = csr_wr_data[0];
            aobu_pkg::CSR_EXP_FRAME:    cfg_in.expected_frame_type    = csr_wr_data;
            aobu_pkg::CSR_EXP_SHOW:     cfg_in.expected_show_frame    = csr_wr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{annex_b_mode: 1'b0, expected_still_picture: 1'b0,
                     expected_frame_type: 2'd0, expected_show_frame: 1'b1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_chan.ready = !full;

   aobu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_chan.valid),
      .in_byte    (req_chan.data_byte),
      .in_eou     (req_chan.end_of_unit),
      .accept     (!full),
      .push       (push),
      .push_entry (push_entry)
   );

   aobu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .head       (head)
   );

   aobu_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

endmodule
